FILE: src/wbc_pkg.sv
// wbc_pkg: request codes and controller/datapath handshake structs for the
// word break checker. No dependencies.

package wbc_pkg;

  localparam logic [1:0] MODE_DICT  = 2'd0;
  localparam logic [1:0] MODE_TEXT  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input request taken this cycle
    logic scan_rd;  // read the dictionary row at the scan address
    logic cmp_en;   // row data is valid, compare against the window
    logic finish;   // load the result register and advance the history, or reset it at text end
  } wbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;  // dictionary holds no words
    logic scan_end;  // scan address is at the last stored word
    logic out_free;  // result register can take a new result
  } wbc_status_t;

endpackage

FILE: src/word_break_checker.sv
// word_break_checker: top level, joins the sequencer and the datapath.
// Depends on wbc_pkg, wbc_ctrl, wbc_dp (and wbc_ram below it).
//
//   channel  direction  tdata                  tuser  tlast
//   in_      slave      symbol[7:0]            mode   is_last
//   out_     master     breakable, overflow    -      text_done
//
// a dictionary or clear request is taken without leaving the idle state
// a text request steps through accept, one row read of the word RAM per
// stored word, the last compare, then loading the result; with no stored
// words it goes from accept straight to loading the result
// reset is synchronous; the word RAM needs no clearing pass
// a waiting result does not block new requests; a text request holds in its
// final step until the result register is free

module word_break_checker #(
  parameter int MAX_WORDS    = 64,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // symbol[7:0]
  input  logic [1:0] in_tuser,   // mode[1:0]
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // prefix_breakable, dict_overflow, zero pad
  output logic       out_tlast
);

  import wbc_pkg::*;

  wbc_cmd_t    cmd;
  wbc_status_t status;

  wbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wbc_dp #(
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: src/wbc_ram.sv
// wbc_ram: generic simple dual port RAM, one write and one registered read.
// No dependencies.

module wbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/wbc_ctrl.sv
// wbc_ctrl: sequencer for the word break checker; steps the dictionary scan
// for each text request. Depends on wbc_pkg.

module wbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [1:0]          in_tuser,
  output logic                in_tready,
  input  wbc_pkg::wbc_status_t status,
  output wbc_pkg::wbc_cmd_t    cmd
);

  import wbc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   rdv_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd.accept  = in_tvalid && (state_r == S_IDLE);
    cmd.scan_rd = (state_r == S_SCAN);
    cmd.cmp_en  = rdv_r;
    cmd.finish  = (state_r == S_FIN) && status.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && in_tuser == MODE_TEXT) begin
          state_nxt = status.cnt_zero ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // read data lands in the cycle after the scan issues it
      rdv_r   <= (state_r == S_SCAN);
    end
  end

endmodule

FILE: src/wbc_dp.sv
// wbc_dp: dictionary loader, word RAM, text window, breakable history and
// result register. Depends on wbc_pkg and wbc_ram.

module wbc_dp #(
  parameter int MAX_WORDS    = 64,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 in_tlast,
  input  wbc_pkg::wbc_cmd_t    cmd,
  output wbc_pkg::wbc_status_t status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  import wbc_pkg::*;

  localparam int L   = MAX_WORD_LEN;
  localparam int LW  = $clog2(L + 1);
  localparam int LLW = $clog2(L + 2);
  localparam int CW  = $clog2(MAX_WORDS + 1);
  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int RW  = LW + 8 * L;

  logic [L-1:0][7:0] buf_r, buf_nxt;
  logic [LLW-1:0]    loading_r;
  logic [CW-1:0]     count_r;
  logic              ovf_r;
  logic [L-1:0][7:0] win_r, win_nxt;
  logic [L:0]        hist_r;
  logic [LW-1:0]     seen_r;
  logic              last_r;
  logic              acc_r;
  logic [AW-1:0]     addr_r;
  logic              out_valid_r;
  logic              out_brk_r;
  logic              out_done_r;
  logic              out_ovf_r;

  logic              dict_acc, text_acc, clear_acc;
  logic              word_fits;
  logic              wr_en;
  logic [LW-1:0]     new_len;
  logic [RW-1:0]     wr_data;
  logic [RW-1:0]     rd_data;
  logic [LW-1:0]     row_len;
  logic [L-1:0]      char_ok;
  logic              row_hit;

  assign dict_acc  = cmd.accept && (in_tuser == MODE_DICT);
  assign text_acc  = cmd.accept && (in_tuser == MODE_TEXT);
  assign clear_acc = cmd.accept && (in_tuser == MODE_CLEAR);

  // newest byte at position zero, so a finished word lies right-aligned
  always_comb begin
    for (int j = 0; j < L; j++) begin
      buf_nxt[j] = (j == 0) ? in_tdata : buf_r[(j == 0) ? 0 : j - 1];
      win_nxt[j] = (j == 0) ? in_tdata : win_r[(j == 0) ? 0 : j - 1];
    end
  end

  assign word_fits = (loading_r < LLW'(L)) && (count_r < CW'(MAX_WORDS));
  assign wr_en     = dict_acc && in_tlast && word_fits;
  assign new_len   = LW'(loading_r) + LW'(1);
  assign wr_data   = {new_len, buf_nxt};

  wbc_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_WORDS)
  ) u_words (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.scan_rd),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign row_len = rd_data[RW-1 -: LW];

  always_comb begin
    for (int j = 0; j < L; j++) begin
      char_ok[j] = (rd_data[8*j +: 8] == win_r[j]) || (LW'(j) >= row_len);
    end
    row_hit = (&char_ok) && (row_len != '0) && (row_len <= seen_r)
              && hist_r[row_len - LW'(1)];
  end

  assign status.cnt_zero = (count_r == '0);
  assign status.scan_end = (CW'(addr_r) == count_r - CW'(1));
  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r   <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      win_r       <= '0;
      hist_r      <= {{L{1'b0}}, 1'b1};
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (dict_acc) begin
        buf_r <= buf_nxt;
        if (in_tlast) begin
          loading_r <= '0;
          if (word_fits) begin
            count_r <= count_r + CW'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end else if (loading_r <= LLW'(L)) begin
          loading_r <= loading_r + LLW'(1);
        end
      end

      if (clear_acc) begin
        loading_r <= '0;
        count_r   <= '0;
        ovf_r     <= 1'b0;
        win_r     <= '0;
        hist_r    <= {{L{1'b0}}, 1'b1};
        seen_r    <= '0;
      end

      if (text_acc) begin
        win_r  <= win_nxt;
        last_r <= in_tlast;
        acc_r  <= 1'b0;
        addr_r <= '0;
        if (seen_r < LW'(L)) begin
          seen_r <= seen_r + LW'(1);
        end
      end

      if (cmd.scan_rd) begin
        addr_r <= addr_r + AW'(1);
      end

      if (cmd.cmp_en && row_hit) begin
        acc_r <= 1'b1;
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        out_brk_r   <= acc_r;
        out_done_r  <= last_r;
        out_ovf_r   <= ovf_r;
        if (last_r) begin
          // end of text, start over with only the empty prefix breakable
          win_r  <= '0;
          hist_r <= {{L{1'b0}}, 1'b1};
          seen_r <= '0;
        end else begin
          hist_r <= {hist_r[L-1:0], acc_r};
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_ovf_r, out_brk_r};
  assign out_tlast  = out_done_r;

endmodule

FILE: src/wbc_checker.sv
// wbc_checker: port-level checks for word_break_checker, bound to the top.
// Depends on wbc_pkg.

module wbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  import wbc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a text request keeps the block busy in the cycle after it is taken
  a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_TEXT |=> !in_tready)
    else $error("request taken right after a text request");

  // pad bits of the result stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'b0)
    else $error("nonzero pad bits in result");

  // no result straight out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind word_break_checker wbc_checker u_wbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
